// ===== hw/rtl/bfa_pkg.sv =====
// Types and constants shared by the bitmap frame allocator.
// Holds the request and response word layouts, status and mode codes
// and the controller state type. Depends on nothing.
`default_nettype none

package bfa_pkg;

   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = 128;
   localparam int WORD_IDX_W = 7;
   localparam int BIT_IDX_W  = 5;
   localparam int FRAME_W    = 12;
   localparam int COUNT_W    = 13;

   localparam logic [COUNT_W-1:0] MAX_FRAMES = 13'd4096;

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_FREE    = 2'd1;
   localparam logic [1:0] MODE_RESERVE = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NONE    = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [FRAME_W-1:0] frame;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FRAME_W-1:0] granted_frame;
      logic [COUNT_W-1:0] used_count;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_CHECK,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Bitmap next-fit page frame allocator: used-bit memory, scan controller
// and the request, response and limit register ports.
// Depends on bfa_pkg for word layouts, codes and the state type.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  bfa_pkg::req_word_type
//   rsp_     out        rsp_valid/rsp_stall  bfa_pkg::rsp_word_type
//   csr_     in         csr_valid/csr_ready  13-bit frame limit
//
// An allocate that grants a frame scans the bitmap word by word, wrapping to frame zero when
// nothing is free above the search index, then writes the word back; one that finds nothing
// skips the write-back. The scan is paced by the single read port, one 32-bit word a cycle.
// Free and reserve read, check and write back the word when the bit changes, skip the write-back
// when it already holds the wanted value, and skip the read when the frame is out of range, as
// does an allocate under a zero limit. Reset clears one valid flag per word, so every word reads
// as all used at once and no clearing pass is needed.
// A finished response waits in the output register while the next request
// is taken; a stalled response holds the controller before its last step.
`default_nettype none

module bitmap_frame_allocator (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire bfa_pkg::req_word_type     req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output bfa_pkg::rsp_word_type          rsp_data,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [bfa_pkg::COUNT_W-1:0]     csr_data
);

   localparam int WB = bfa_pkg::WORD_BITS;
   localparam int WI = bfa_pkg::WORD_IDX_W;
   localparam int BI = bfa_pkg::BIT_IDX_W;
   localparam int FW = bfa_pkg::FRAME_W;
   localparam int CW = bfa_pkg::COUNT_W;

   // Bitmap memory and its per-word valid flags.
   logic [WB-1:0]                 bitmap_mem [bfa_pkg::WORD_COUNT];
   logic [bfa_pkg::WORD_COUNT-1:0] word_vld_ff;
   logic [WB-1:0]                 rdata_ff;
   logic                          rvld_ff;
   logic [WI-1:0]                 rd_addr;
   logic                          wr_en;

   bfa_pkg::state_type state_ff, state_in;

   logic [1:0]    item_mode_ff, item_mode_in;
   logic [FW-1:0] item_frame_ff, item_frame_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] search_ff, search_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic          wrap_ff, wrap_in;
   logic [WI-1:0] issue_w_ff, issue_w_in;
   logic          issue_left_ff, issue_left_in;
   logic [WI-1:0] eval_w_ff, eval_w_in;
   logic          eval_ok_ff, eval_ok_in;
   logic [WI-1:0] last_w_ff, last_w_in;
   logic [WI-1:0] wr_addr_ff, wr_addr_in;
   logic [WB-1:0] wr_data_ff, wr_data_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [FW-1:0] res_frame_ff, res_frame_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bfa_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic          req_fire;
   logic          csr_fire;
   logic          rsp_load;
   logic [WB-1:0] cur_word;
   logic [WB-1:0] lo_mask;
   logic [WB-1:0] hi_mask;
   logic [WB-1:0] free_vec;
   logic          scan_found;
   logic [BI-1:0] scan_idx;
   logic          scan_end;
   logic          wrap_pending;
   logic [CW-1:0] start_lo;
   logic [CW-1:0] start_hi_m1;
   logic [CW-1:0] search_m1;
   logic          start_wrap;
   logic          item_bit;
   logic [WB-1:0] item_onehot;
   logic [CW-1:0] csr_sat;

   assign req_stall = (state_ff != bfa_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_load  = (state_ff == bfa_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign wr_en     = (state_ff == bfa_pkg::ST_WRITE);
   assign csr_sat   = (csr_data > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : csr_data;

   // A word never written since reset reads as all frames used.
   assign cur_word = rvld_ff ? rdata_ff : {WB{1'b1}};

   // Bounds of the first scan range: from the search index up to the limit,
   // or straight to the wrapped range when the index is at or past the limit.
   assign start_wrap  = !(search_ff < total_ff);
   assign start_lo    = start_wrap ? '0 : search_ff;
   assign start_hi_m1 = total_ff - CW'(1);
   assign search_m1   = search_ff - CW'(1);

   // Frames of the evaluated word that lie inside [lo, hi).
   assign lo_mask = (eval_w_ff == lo_ff[FW-1:BI]) ? ({WB{1'b1}} << lo_ff[BI-1:0])
                                                  : {WB{1'b1}};
   assign hi_mask = ({1'b0, eval_w_ff} == hi_ff[CW-1:BI])
                    ? ((WB'(1) << hi_ff[BI-1:0]) - WB'(1)) : {WB{1'b1}};
   assign free_vec   = ~cur_word & lo_mask & hi_mask;
   assign scan_found = eval_ok_ff && (|free_vec);
   assign scan_end   = eval_ok_ff && !scan_found && (eval_w_ff == last_w_ff);
   assign wrap_pending = !wrap_ff && (search_ff != '0);

   always_comb begin
      scan_idx = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            scan_idx = BI'(b);
         end
      end
   end

   assign item_onehot = WB'(1) << item_frame_ff[BI-1:0];
   assign item_bit    = cur_word[item_frame_ff[BI-1:0]];

   always_comb begin
      case (state_ff)
         bfa_pkg::ST_SCAN:  rd_addr = issue_w_ff;
         default:           rd_addr = item_frame_ff[FW-1:BI];
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.mode)
                  bfa_pkg::MODE_ALLOC: begin
                     state_in = (total_ff == '0) ? bfa_pkg::ST_DONE : bfa_pkg::ST_SCAN;
                  end
                  bfa_pkg::MODE_FREE: begin
                     state_in = (req_data.frame != '0 && {1'b0, req_data.frame} < total_ff)
                                ? bfa_pkg::ST_READ : bfa_pkg::ST_DONE;
                  end
                  bfa_pkg::MODE_RESERVE: begin
                     state_in = ({1'b0, req_data.frame} < total_ff)
                                ? bfa_pkg::ST_READ : bfa_pkg::ST_DONE;
                  end
                  default: state_in = bfa_pkg::ST_DONE;
               endcase
            end
         end
         bfa_pkg::ST_SCAN: begin
            if (scan_found) begin
               state_in = bfa_pkg::ST_WRITE;
            end else if (scan_end && !wrap_pending) begin
               state_in = bfa_pkg::ST_DONE;
            end
         end
         bfa_pkg::ST_READ:  state_in = bfa_pkg::ST_CHECK;
         bfa_pkg::ST_CHECK: begin
            if (item_mode_ff == bfa_pkg::MODE_FREE) begin
               state_in = item_bit ? bfa_pkg::ST_WRITE : bfa_pkg::ST_DONE;
            end else begin
               state_in = item_bit ? bfa_pkg::ST_DONE : bfa_pkg::ST_WRITE;
            end
         end
         bfa_pkg::ST_WRITE: state_in = bfa_pkg::ST_DONE;
         bfa_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         default: state_in = bfa_pkg::ST_IDLE;
      endcase
   end

   // Datapath and counters.
   always_comb begin
      item_mode_in  = item_mode_ff;
      item_frame_in = item_frame_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      search_in     = search_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      wrap_in       = wrap_ff;
      issue_w_in    = issue_w_ff;
      issue_left_in = issue_left_ff;
      eval_w_in     = eval_w_ff;
      eval_ok_in    = 1'b0;
      last_w_in     = last_w_ff;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);

      case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (req_fire) begin
               item_mode_in  = req_data.mode;
               item_frame_in = req_data.frame;
               res_frame_in  = '0;
               res_status_in = (req_data.mode == bfa_pkg::MODE_ALLOC)
                               ? bfa_pkg::STATUS_NONE : bfa_pkg::STATUS_IGNORED;
               lo_in         = start_lo;
               hi_in         = total_ff;
               wrap_in       = start_wrap;
               issue_w_in    = start_lo[FW-1:BI];
               last_w_in     = start_hi_m1[FW-1:BI];
               issue_left_in = 1'b1;
            end
         end
         bfa_pkg::ST_SCAN: begin
            // Keep one read in flight ahead of the word being examined.
            if (issue_left_ff) begin
               eval_w_in     = issue_w_ff;
               eval_ok_in    = 1'b1;
               issue_w_in    = issue_w_ff + WI'(1);
               issue_left_in = (issue_w_ff != last_w_ff);
            end
            if (scan_found) begin
               wr_addr_in    = eval_w_ff;
               wr_data_in    = cur_word | (WB'(1) << scan_idx);
               res_frame_in  = {eval_w_ff, scan_idx};
               res_status_in = bfa_pkg::STATUS_DONE;
            end else if (scan_end && wrap_pending) begin
               // Nothing free above the index: scan the frames below it.
               wrap_in       = 1'b1;
               lo_in         = '0;
               hi_in         = search_ff;
               issue_w_in    = '0;
               last_w_in     = search_m1[FW-1:BI];
               issue_left_in = 1'b1;
               eval_ok_in    = 1'b0;
            end
         end
         bfa_pkg::ST_CHECK: begin
            wr_addr_in    = item_frame_ff[FW-1:BI];
            if (item_mode_ff == bfa_pkg::MODE_FREE) begin
               wr_data_in = cur_word & ~item_onehot;
               res_status_in = item_bit ? bfa_pkg::STATUS_DONE : bfa_pkg::STATUS_IGNORED;
            end else begin
               wr_data_in = cur_word | item_onehot;
               res_status_in = item_bit ? bfa_pkg::STATUS_IGNORED : bfa_pkg::STATUS_DONE;
            end
         end
         bfa_pkg::ST_WRITE: begin
            if (item_mode_ff == bfa_pkg::MODE_FREE) begin
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
               end
               if ({1'b0, item_frame_ff} < search_ff) begin
                  search_in = {1'b0, item_frame_ff};
               end
            end else begin
               if (count_ff < bfa_pkg::MAX_FRAMES) begin
                  count_in = count_ff + CW'(1);
               end
               if (item_mode_ff == bfa_pkg::MODE_ALLOC) begin
                  search_in = {1'b0, res_frame_ff} + CW'(1);
               end
            end
         end
         bfa_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_data_in.status        = res_status_ff;
               rsp_data_in.granted_frame = res_frame_ff;
               rsp_data_in.used_count    = count_ff;
            end
         end
         default: ;
      endcase

      if (csr_fire) begin
         total_in = csr_sat;
         count_in = csr_sat;
      end
   end

   // Bitmap memory, one read and one write port, registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr_ff] <= wr_data_ff;
      end
      rdata_ff <= bitmap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_vld_ff   <= '0;
         rvld_ff       <= 1'b0;
         state_ff      <= bfa_pkg::ST_IDLE;
         total_ff      <= bfa_pkg::MAX_FRAMES;
         count_ff      <= bfa_pkg::MAX_FRAMES;
         search_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         issue_left_ff <= 1'b0;
         eval_ok_ff    <= 1'b0;
         wrap_ff       <= 1'b0;
      end else begin
         if (wr_en) begin
            word_vld_ff[wr_addr_ff] <= 1'b1;
         end
         rvld_ff       <= word_vld_ff[rd_addr];
         state_ff      <= state_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
         search_ff     <= search_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_left_ff <= issue_left_in;
         eval_ok_ff    <= eval_ok_in;
         wrap_ff       <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff  <= item_mode_in;
      item_frame_ff <= item_frame_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      issue_w_ff    <= issue_w_in;
      eval_w_ff     <= eval_w_in;
      last_w_ff     <= last_w_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the bitmap frame allocator.
// Depends on bfa_pkg and bitmap_frame_allocator only: a directed plan, then
// random phases at varied frame limits, each word checked against the plan or a predictor.
`timescale 1ns / 1ps

module tb;

   localparam int STALL_LIMIT = 3000;
   localparam int TARGET_ITEMS = 750;

   // A mode code the block does not define.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum bit {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [12:0]           limit;
      bfa_pkg::req_word_type word;
      bit                    typed;
      bfa_pkg::rsp_word_type want;
   } plan_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   bfa_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   bfa_pkg::rsp_word_type rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [12:0]           csr_data = '0;

   // Predictor state: one used flag per frame, used count, next-fit index, limit.
   logic         frame_used [0:4095];
   logic [12:0]  frames_taken;
   int unsigned  next_fit;
   int unsigned  frame_limit;

   bfa_pkg::rsp_word_type owed_rsp [$];
   int                    errors = 0;
   bit                    quiet = 1'b0;
   int                    hold = 0;
   int                    idle_cycles = 0;
   bfa_pkg::rsp_word_type want;

   plan_row_type plan [0:27] = '{
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_NONE, 12'd0, 13'd4096}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_IGNORED, 12'd0, 13'd4096}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'd4095}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd0, 13'd4095}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'd4095}, 1'b1,
        '{bfa_pkg::STATUS_IGNORED, 12'd0, 13'd4095}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd4095, 13'd4096}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_NONE, 12'd0, 13'd4096}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'd1}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd0, 13'd4095}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'd2048}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd0, 13'd4094}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_RESERVE, 12'd2048}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd0, 13'd4095}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_RESERVE, 12'd2048}, 1'b1,
        '{bfa_pkg::STATUS_IGNORED, 12'd0, 13'd4095}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd1, 13'd4096}},
      '{ROW_REQ, 13'd0, '{MODE_UNUSED, 12'hFFF}, 1'b1,
        '{bfa_pkg::STATUS_IGNORED, 12'd0, 13'd4096}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'h555}, 1'b0, '0},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'hAAA}, 1'b0, '0},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_RESERVE, 12'hAAA}, 1'b0, '0},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b0, '0},
      '{ROW_CSR, 13'd0, '0, 1'b0, '0},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_NONE, 12'd0, 13'd0}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'd5}, 1'b1,
        '{bfa_pkg::STATUS_IGNORED, 12'd0, 13'd0}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_RESERVE, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_IGNORED, 12'd0, 13'd0}},
      '{ROW_CSR, 13'd8191, '0, 1'b0, '0},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_FREE, 12'd4095}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd0, 13'd4095}},
      '{ROW_CSR, 13'd1, '0, 1'b0, '0},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_RESERVE, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_IGNORED, 12'd0, 13'd1}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b1,
        '{bfa_pkg::STATUS_NONE, 12'd0, 13'd1}},
      '{ROW_CSR, 13'd4096, '0, 1'b0, '0},
      // The count is already at its ceiling, so this reserve must not raise it.
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_RESERVE, 12'd4095}, 1'b1,
        '{bfa_pkg::STATUS_DONE, 12'd0, 13'd4096}},
      '{ROW_REQ, 13'd0, '{bfa_pkg::MODE_ALLOC, 12'd0}, 1'b0, '0}
   };

   bitmap_frame_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void bump_count();
      if (frames_taken < bfa_pkg::MAX_FRAMES) begin
         frames_taken = frames_taken + 13'd1;
      end
   endfunction

   // Applies one request word to the predicted bitmap and returns its response.
   function automatic bfa_pkg::rsp_word_type apply_to_bitmap(input bfa_pkg::req_word_type w);
      bfa_pkg::rsp_word_type r;
      int unsigned  i;
      int unsigned  hit;
      bit           found;
      r = '0;
      r.status = bfa_pkg::STATUS_IGNORED;
      found = 1'b0;
      hit = 0;
      case (w.mode)
         bfa_pkg::MODE_ALLOC: begin
            for (i = next_fit; i < frame_limit && !found; i++) begin
               if (!frame_used[i]) begin
                  found = 1'b1;
                  hit = i;
               end
            end
            // The wrapped pass never goes past the limit, even when the index is beyond it.
            for (i = 0; i < next_fit && i < frame_limit && !found; i++) begin
               if (!frame_used[i]) begin
                  found = 1'b1;
                  hit = i;
               end
            end
            if (found) begin
               frame_used[hit] = 1'b1;
               bump_count();
               next_fit = hit + 1;
               r.granted_frame = 12'(hit);
               r.status = bfa_pkg::STATUS_DONE;
            end else begin
               r.status = bfa_pkg::STATUS_NONE;
            end
         end
         bfa_pkg::MODE_FREE: begin
            if (w.frame != 0 && w.frame < frame_limit && frame_used[w.frame]) begin
               frame_used[w.frame] = 1'b0;
               if (frames_taken > 0) begin
                  frames_taken = frames_taken - 13'd1;
               end
               if (w.frame < next_fit) begin
                  next_fit = w.frame;
               end
               r.status = bfa_pkg::STATUS_DONE;
            end
         end
         bfa_pkg::MODE_RESERVE: begin
            if (w.frame < frame_limit && !frame_used[w.frame]) begin
               frame_used[w.frame] = 1'b1;
               bump_count();
               r.status = bfa_pkg::STATUS_DONE;
            end
         end
         default: ;
      endcase
      r.used_count = frames_taken;
      return r;
   endfunction

   function automatic logic [11:0] pick_frame();
      if (frame_limit == 0 || $urandom_range(0, 9) == 0) begin
         return 12'($urandom);
      end
      return 12'($urandom_range(0, frame_limit - 1));
   endfunction

   task automatic push_req(input bfa_pkg::req_word_type w, input bit typed,
                           input bfa_pkg::rsp_word_type typed_want);
      int                    gap;
      bfa_pkg::rsp_word_type predicted;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_to_bitmap(w);
      owed_rsp.push_back(typed ? typed_want : predicted);
   endtask

   // The limit is only written once every outstanding word has come back.
   task automatic write_limit(input logic [12:0] v);
      logic [12:0] sat;
      req_valid <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sat = (v > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : v;
      frame_limit = sat;
      frames_taken = sat;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp.size() == 0) begin
               $error("response word with nothing outstanding: %p", rsp_data);
               errors++;
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.granted_frame !== want.granted_frame) begin
                  $error("granted_frame: expected %0d, got %0d",
                         want.granted_frame, rsp_data.granted_frame);
                  errors++;
               end
               if (rsp_data.used_count !== want.used_count) begin
                  $error("used_count: expected %0d, got %0d",
                         want.used_count, rsp_data.used_count);
                  errors++;
               end
            end
            hold = quiet ? 0 : $urandom_range(0, 16);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[bitmap_frame_allocator] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stim
      int                    r;
      int                    sel;
      int                    k;
      int                    phase_len;
      int                    counted;
      logic [12:0]           lim;
      bfa_pkg::req_word_type w;
      for (int f = 0; f < 4096; f++) begin
         frame_used[f] = 1'b1;
      end
      frames_taken = bfa_pkg::MAX_FRAMES;
      next_fit = 0;
      frame_limit = bfa_pkg::MAX_FRAMES;
      counted = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_limit(plan[i].limit);
         end else begin
            push_req(plan[i].word, plan[i].typed, plan[i].want);
            counted++;
         end
      end

      while (counted < TARGET_ITEMS) begin
         r = $urandom_range(0, 19);
         case (r)
            0:       lim = 13'd0;
            1:       lim = 13'($urandom_range(4097, 8191));
            2, 3:    lim = 13'd4096;
            4:       lim = 13'd1;
            default: lim = 13'($urandom_range(2, 96));
         endcase
         write_limit(lim);
         quiet = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 70);
         // Chiefly frees interleaved with allocations, so the scan finds real holes.
         for (k = 0; k < phase_len && counted < TARGET_ITEMS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
               w.mode = bfa_pkg::MODE_FREE;
               w.frame = pick_frame();
            end else if (sel < 75) begin
               w.mode = bfa_pkg::MODE_ALLOC;
               w.frame = 12'($urandom);
            end else if (sel < 90) begin
               w.mode = bfa_pkg::MODE_RESERVE;
               w.frame = pick_frame();
            end else begin
               w.mode = 2'($urandom_range(0, 3));
               w.frame = 12'($urandom);
            end
            push_req(w, 1'b0, '0);
            counted++;
         end
      end

      req_valid <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (errors == 0) begin
         $display("[bitmap_frame_allocator] OK");
      end else begin
         $display("[bitmap_frame_allocator] ERROR");
      end
      $finish;
   end

endmodule
